FILE: hw/rtl/iepm_pkg.sv
// shared types and constants for the i2c eeprom page master
// depends on nothing; every other file imports it
package iepm_pkg;

  localparam int MAX_BYTES_DEF = 64;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 8;

  localparam logic [6:0] DEV_ADDR_RESET  = 7'h53;
  localparam logic [7:0] ACK_LIMIT_RESET = 8'd250;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_LIMIT      = 8'd1;

  // action codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] mem_address;
    logic [6:0] byte_count;
    logic [7:0] write_data;
    logic       sda_in;
  } tick_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       byte_taken;
    logic       busy_res;
    logic       done_res;
    logic       success;
  } res_t;

endpackage

FILE: hw/rtl/iepm_if.sv
// valid/ready channel interfaces: tick input, result output, register writes
// depends on iepm_pkg
interface iepm_tick_if import iepm_pkg::*; ();
  logic  valid;
  logic  ready;
  tick_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface iepm_res_if import iepm_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface iepm_cfg_if import iepm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/iepm_in_reg.sv
// input register for tick beats
// depends on iepm_pkg and iepm_tick_if
module iepm_in_reg
  import iepm_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  iepm_tick_if.sink       in_ch,
  input  logic            advance,
  output logic            tick_valid,
  output tick_t           tick_data
);

  logic  valid_r;
  tick_t data_r;

  assign in_ch.ready = !valid_r || advance;
  assign tick_valid  = valid_r;
  assign tick_data   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      data_r <= in_ch.data;
    end
  end

endmodule

FILE: hw/rtl/iepm_out_reg.sv
// result register driving the output channel
// depends on iepm_pkg and iepm_res_if
module iepm_out_reg
  import iepm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  iepm_res_if.source out_ch,
  input  logic      load,
  input  res_t      res_data,
  output logic      can_load
);

  logic valid_r;
  res_t data_r;

  assign can_load     = !valid_r || out_ch.ready;
  assign out_ch.valid = valid_r;
  assign out_ch.data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res_data;
    end
  end

endmodule

FILE: hw/rtl/iepm_engine.sv
// bus sequencer: phase state, config registers and the per-tick step logic
// depends on iepm_pkg and iepm_cfg_if
module iepm_engine
  import iepm_pkg::*;
#(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  iepm_cfg_if.sink   cfg_ch,
  input  logic       advance,
  input  tick_t      tick_data,
  output res_t       res_data
);

  localparam int BL_W = $clog2(MAX_BYTES + 1);

  localparam logic [4:0] PH_IDLE      = 5'd0;
  localparam logic [4:0] PH_START1    = 5'd1;
  localparam logic [4:0] PH_START2    = 5'd2;
  localparam logic [4:0] PH_TX_DEVW   = 5'd3;
  localparam logic [4:0] PH_TX_MEM    = 5'd4;
  localparam logic [4:0] PH_TX_DATA   = 5'd5;
  localparam logic [4:0] PH_TX_DEVR   = 5'd6;
  localparam logic [4:0] PH_ACK_DEVW  = 5'd7;
  localparam logic [4:0] PH_ACK_MEM   = 5'd8;
  localparam logic [4:0] PH_ACK_DATA  = 5'd9;
  localparam logic [4:0] PH_ACK_DEVR  = 5'd10;
  localparam logic [4:0] PH_RX        = 5'd11;
  localparam logic [4:0] PH_MACK      = 5'd12;
  localparam logic [4:0] PH_STOP_OK   = 5'd13;
  localparam logic [4:0] PH_STOP_FAIL = 5'd14;
  localparam logic [4:0] PH_STOP_MEM  = 5'd15;
  localparam logic [4:0] PH_STOP_DEVR = 5'd16;
  localparam logic [4:0] PH_TX2ACK    = PH_ACK_DEVW - PH_TX_DEVW;

  logic [6:0]      dev_addr_r;
  logic [7:0]      ack_limit_r;
  logic [4:0]      phase_r, phase_nxt;
  logic [2:0]      tick_r, tick_nxt;
  logic [2:0]      bit_r, bit_nxt;
  logic [7:0]      shift_r, shift_nxt;
  logic [BL_W-1:0] left_r, left_nxt;
  logic [7:0]      poll_r, poll_nxt;
  logic            rmode_r, rmode_nxt;
  logic [7:0]      addr_r, addr_nxt;

  logic       go_en;
  logic [4:0] go_ph;
  logic [8:0] cnt;
  res_t       res;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r  <= DEV_ADDR_RESET;
      ack_limit_r <= ACK_LIMIT_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_DEVICE_ADDRESS: dev_addr_r  <= cfg_ch.data[6:0];
        CFG_ACK_LIMIT:      ack_limit_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    left_nxt  = left_r;
    poll_nxt  = poll_r;
    rmode_nxt = rmode_r;
    addr_nxt  = addr_r;
    go_en     = 1'b0;
    go_ph     = PH_IDLE;
    cnt       = {2'b00, tick_data.byte_count};
    res       = '0;
    res.scl_release = 1'b1;
    res.sda_release = 1'b1;

    // launch, only from idle
    if (phase_r == PH_IDLE &&
        (tick_data.action == ACT_WRITE || tick_data.action == ACT_READ)) begin
      if (cnt > 9'(MAX_BYTES)) begin
        cnt = 9'(MAX_BYTES);
      end
      addr_nxt  = tick_data.mem_address;
      left_nxt  = cnt[BL_W-1:0];
      rmode_nxt = (tick_data.action == ACT_READ);
      phase_nxt = PH_START1;
      tick_nxt  = 3'd0;
      bit_nxt   = 3'd0;
      poll_nxt  = 8'd0;
    end

    if (phase_nxt != PH_IDLE) begin
      res.busy_res = 1'b1;
      case (phase_nxt)
        PH_START1, PH_START2: begin
          res.scl_release = 1'b1;
          res.sda_release = (tick_nxt < 3'd4);
          if (tick_nxt == 3'd7) begin
            shift_nxt = {dev_addr_r, phase_nxt == PH_START2};
            go_en     = 1'b1;
            go_ph     = (phase_nxt == PH_START2) ? PH_TX_DEVR : PH_TX_DEVW;
          end else begin
            tick_nxt = tick_nxt + 3'd1;
          end
        end
        PH_TX_DEVW, PH_TX_MEM, PH_TX_DATA, PH_TX_DEVR: begin
          if (phase_nxt == PH_TX_DATA && tick_nxt == 3'd0 && bit_nxt == 3'd0) begin
            shift_nxt      = tick_data.write_data;
            res.byte_taken = 1'b1;
          end
          res.sda_release = shift_nxt[3'd7 - bit_nxt];
          res.scl_release = (tick_nxt == 3'd2 || tick_nxt == 3'd3);
          if (tick_nxt >= 3'd5) begin
            tick_nxt = 3'd0;
            if (bit_nxt == 3'd7) begin
              go_en = 1'b1;
              go_ph = phase_nxt + PH_TX2ACK;
            end else begin
              bit_nxt = bit_nxt + 3'd1;
            end
          end else begin
            tick_nxt = tick_nxt + 3'd1;
          end
        end
        PH_ACK_DEVW, PH_ACK_MEM, PH_ACK_DATA, PH_ACK_DEVR: begin
          res.sda_release = 1'b1;
          res.scl_release = (tick_nxt != 3'd0);
          if (tick_nxt < 3'd2) begin
            tick_nxt = tick_nxt + 3'd1;
          end else if (!tick_data.sda_in) begin
            // acknowledge seen
            go_en = 1'b1;
            case (phase_nxt)
              PH_ACK_DEVW: begin
                shift_nxt = addr_nxt;
                go_ph     = PH_TX_MEM;
              end
              PH_ACK_MEM: begin
                go_ph = rmode_nxt ? PH_START2 :
                        (left_nxt == '0) ? PH_STOP_OK : PH_TX_DATA;
              end
              PH_ACK_DATA: begin
                if (left_nxt != '0) begin
                  left_nxt = left_nxt - BL_W'(1);
                end
                go_ph = (left_nxt == '0) ? PH_STOP_OK : PH_TX_DATA;
              end
              default: begin
                if (left_nxt == '0) begin
                  go_ph = PH_STOP_OK;
                end else begin
                  shift_nxt = 8'd0;
                  go_ph     = PH_RX;
                end
              end
            endcase
          end else if (poll_nxt >= ack_limit_r) begin
            go_en = 1'b1;
            case (phase_nxt)
              PH_ACK_MEM:  go_ph = PH_STOP_MEM;
              PH_ACK_DEVR: go_ph = PH_STOP_DEVR;
              default:     go_ph = PH_STOP_FAIL;
            endcase
          end else begin
            poll_nxt = poll_nxt + 8'd1;
          end
        end
        PH_RX: begin
          res.sda_release = 1'b1;
          res.scl_release = (tick_nxt == 3'd2);
          if (tick_nxt >= 3'd2) begin
            shift_nxt = {shift_nxt[6:0], tick_data.sda_in};
            if (bit_nxt == 3'd7) begin
              res.read_valid = 1'b1;
              res.read_byte  = shift_nxt;
              go_en          = 1'b1;
              go_ph          = PH_MACK;
            end else begin
              bit_nxt  = bit_nxt + 3'd1;
              tick_nxt = 3'd0;
            end
          end else begin
            tick_nxt = tick_nxt + 3'd1;
          end
        end
        PH_MACK: begin
          // nack on the last byte
          res.sda_release = (left_nxt <= BL_W'(1));
          res.scl_release = (tick_nxt >= 3'd2);
          if (tick_nxt >= 3'd3) begin
            if (left_nxt != '0) begin
              left_nxt = left_nxt - BL_W'(1);
            end
            go_en = 1'b1;
            if (left_nxt == '0) begin
              go_ph = PH_STOP_OK;
            end else begin
              shift_nxt = 8'd0;
              go_ph     = PH_RX;
            end
          end else begin
            tick_nxt = tick_nxt + 3'd1;
          end
        end
        PH_STOP_OK, PH_STOP_FAIL, PH_STOP_MEM, PH_STOP_DEVR: begin
          res.scl_release = (tick_nxt >= 3'd4);
          res.sda_release = (tick_nxt >= 3'd4);
          if (tick_nxt == 3'd7) begin
            go_en = 1'b1;
            case (phase_nxt)
              PH_STOP_OK: begin
                res.done_res = 1'b1;
                res.success  = 1'b1;
                go_ph        = PH_IDLE;
              end
              PH_STOP_FAIL: begin
                res.done_res = 1'b1;
                go_ph        = PH_IDLE;
              end
              PH_STOP_MEM: begin
                // ignored timeout on the memory address, carry on
                go_ph = rmode_nxt ? PH_START2 :
                        (left_nxt == '0) ? PH_STOP_OK : PH_TX_DATA;
              end
              default: begin
                if (left_nxt == '0) begin
                  go_ph = PH_STOP_OK;
                end else begin
                  shift_nxt = 8'd0;
                  go_ph     = PH_RX;
                end
              end
            endcase
          end else begin
            tick_nxt = tick_nxt + 3'd1;
          end
        end
        default: begin
          res.busy_res = 1'b0;
          go_en        = 1'b1;
          go_ph        = PH_IDLE;
        end
      endcase
    end

    if (go_en) begin
      phase_nxt = go_ph;
      tick_nxt  = 3'd0;
      bit_nxt   = 3'd0;
      poll_nxt  = 8'd0;
    end
  end

  assign res_data = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= 3'd0;
      bit_r   <= 3'd0;
      shift_r <= 8'd0;
      left_r  <= '0;
      poll_r  <= 8'd0;
      rmode_r <= 1'b0;
      addr_r  <= 8'd0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      left_r  <= left_nxt;
      poll_r  <= poll_nxt;
      rmode_r <= rmode_nxt;
      addr_r  <= addr_nxt;
    end
  end

endmodule

FILE: hw/rtl/i2c_eeprom_page_master_core.sv
// top level of the tick-driven i2c eeprom page master
// depends on iepm_pkg, iepm_if, iepm_in_reg, iepm_engine and iepm_out_reg
//
// usage
//   in_ch carries one beat per 1 us bus tick: action (plain tick, launch page
//   write, launch page read), mem_address and byte_count taken at launch,
//   write_data taken on the beat whose result reports byte_taken, and the
//   sampled sda level
//   out_ch returns exactly one result beat per input beat, in order: the
//   open-drain release levels for scl and sda, read bytes with read_valid,
//   and busy / done / success status
//   cfg_ch writes device_address (index 0) and ack_limit (index 1); it is
//   always ready and should only be used while no transaction is running
// timing
//   a beat waits in the input register, then the step logic updates the
//   bus state and loads the result register; one beat is accepted per cycle
//   when the receiver keeps up
// reset
//   rst_n low returns to idle, drops both channel registers and restores
//   device_address 0x53 and ack_limit 250
// stall
//   when out_ch.ready is low and a result is held, the result register
//   holds, the step logic and the input register freeze, and in_ch.ready
//   drops once the input register is full; nothing is lost or repeated
module i2c_eeprom_page_master_core
  import iepm_pkg::*;
#(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  iepm_tick_if.sink   in_ch,
  iepm_res_if.source  out_ch,
  iepm_cfg_if.sink    cfg_ch
);

  logic  tick_valid;
  tick_t tick_data;
  res_t  res_data;
  logic  can_load;
  logic  advance;

  // a stored tick moves on when the result register has room
  assign advance = tick_valid && can_load;

  iepm_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (advance),
    .tick_valid (tick_valid),
    .tick_data  (tick_data)
  );

  iepm_engine #(
    .MAX_BYTES (MAX_BYTES)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ch    (cfg_ch),
    .advance   (advance),
    .tick_data (tick_data),
    .res_data  (res_data)
  );

  iepm_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .out_ch   (out_ch),
    .load     (advance),
    .res_data (res_data),
    .can_load (can_load)
  );

endmodule
